/* src/cbc_pkg.sv */
package cbc_pkg;

  // Unit vector components are held with this many fraction bits.
  localparam int UNIT_BITS = 30;
  // Integer square root of the squared distance: 33 result bits.
  localparam int ROOT_W = 33;
  // Squared horizontal distance, with headroom for the root extraction.
  localparam int D2_W = 66;
  // Quotient bits of one unit vector component magnitude.
  localparam int Q_W = 31;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_CENTER_X      = 3'd0;
  localparam cfg_idx_t REG_CENTER_Y      = 3'd1;
  localparam cfg_idx_t REG_ARENA_RADIUS  = 3'd2;
  localparam cfg_idx_t REG_ENGAGE_RADIUS = 3'd3;
  localparam cfg_idx_t REG_CONFINE_EN    = 3'd4;

  // One body update as it travels down the pipeline.
  typedef struct packed {
    logic               act;
    logic               clamp;
    logic               start;
    logic               neg_x;
    logic               neg_y;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } item_t;

  // Saturate a wide signed value to the 32 bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sh07FFFFFFF;
    lo = -36'sh080000000;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

/* src/circular_boundary_confine.sv */
// Circular arena confinement for body updates in the horizontal plane.
//
// Input transactions carry a battle flag, a position and a velocity (Q23.8).
// Each accepted input transaction yields exactly one output transaction, in
// order. Before battle the block reports whether the body lies within the
// engage radius. During battle, with confining enabled, a body outside the
// arena radius is moved radially onto the circle and any outward horizontal
// velocity is removed; height and vertical velocity always pass through.
//
// The pipeline has 74 register stages. While the receiver does not stall, the
// pipeline takes one transaction per cycle. Its depth is set by the
// bit-per-stage square root (33 stages) and the two bit-per-stage dividers
// forming the unit vector (31 stages), plus multiply and rounding stages.
//
// When the receiver stalls, the whole pipeline holds and in_ready drops; no
// transaction is lost or repeated. Reset (synchronous, active low) empties the
// pipeline and restores the registers: centre 0, radii 0, confining on. The user
// must write registers via cfg_we/cfg_index/cfg_wdata while idle (not enforced).
module circular_boundary_confine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cbc_pkg::cfg_idx_t     cfg_index,
  input  logic [31:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_battle_active,
  input  logic signed [31:0]    in_pos_x,
  input  logic signed [31:0]    in_pos_y,
  input  logic signed [31:0]    in_pos_z,
  input  logic signed [31:0]    in_vel_x,
  input  logic signed [31:0]    in_vel_y,
  input  logic signed [31:0]    in_vel_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_new_pos_x,
  output logic signed [31:0]    out_new_pos_y,
  output logic signed [31:0]    out_new_pos_z,
  output logic signed [31:0]    out_new_vel_x,
  output logic signed [31:0]    out_new_vel_y,
  output logic signed [31:0]    out_new_vel_z,
  output logic                  out_was_clamped,
  output logic                  out_start_battle
);
  import cbc_pkg::*;

  // Stage map: 0 difference, 1 squares, 2 sum, 3 flags and root start,
  // 4..36 root steps, 37 divider start, 38..68 divider steps, 69..73 products.
  localparam int ST_D  = 3;
  localparam int ST_E  = ST_D + ROOT_W + 1;
  localparam int ST_M1 = ST_E + Q_W + 1;
  localparam int NST   = ST_M1 + 5;
  localparam int RT_W  = D2_W + 2;
  localparam logic [63:0] HALF_UNIT = 64'd1 << (UNIT_BITS - 1);

  // Configuration registers.
  logic signed [31:0] cx_r, cy_r;
  logic [30:0]        ar_r, er_r;
  logic               en_r;
  logic [61:0]        ra2_r, re2_r;

  // Pipeline control and item payload.
  logic  adv;
  logic  vld_r   [NST];
  item_t it_r    [NST];
  item_t it_nxt  [NST];

  // Squared distance.
  logic [63:0]     sqx_r, sqy_r;
  logic [D2_W-1:0] d2_r;

  // Square root: remainder and partial root per step.
  logic [D2_W-1:0]   rt_rem_r   [ROOT_W+1];
  logic [D2_W-1:0]   rt_rem_nxt [ROOT_W+1];
  logic [ROOT_W-1:0] rt_root_r  [ROOT_W+1];
  logic [ROOT_W-1:0] rt_root_nxt[ROOT_W+1];

  // Dividers for the two unit vector components.
  logic [ROOT_W-1:0] dv_dist_r [Q_W+1];
  logic [ROOT_W-1:0] dv_rem_r  [2][Q_W+1];
  logic [ROOT_W-1:0] dv_rem_nxt[2][Q_W+1];
  logic [Q_W-1:0]    dv_low_r  [2][Q_W+1];
  logic [Q_W-1:0]    dv_q_r    [2][Q_W+1];
  logic [Q_W-1:0]    dv_q_nxt  [2][Q_W+1];

  // Product and rounding stages.
  logic [Q_W-1:0]      q1_r[2], q2_r[2], q3_r[2];
  logic [61:0]         pm_r[2];
  logic signed [63:0]  vu_r[2];
  logic [31:0]         pr_r[2];
  logic signed [63:0]  vs_r;
  logic [32:0]         s_r;
  logic                s_pos_r, s_pos4_r;
  logic [63:0]         cv_r[2];

  logic [63:0] num[2];
  logic [63:0] vmag;
  logic [63:0] vrnd;
  logic [63:0] cvrnd[2];

  assign adv      = !vld_r[NST-1] || out_ready;
  assign in_ready = adv;

  // Root steps: one result bit per stage.
  assign rt_rem_nxt[0]  = d2_r;
  assign rt_root_nxt[0] = '0;
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int B = ROOT_W - 1 - k;
    logic [RT_W-1:0] trial;
    logic [RT_W-1:0] rem_w;
    logic            take;
    assign trial = ({{(RT_W-ROOT_W){1'b0}}, rt_root_r[k]} << (B + 1))
                 | (RT_W'(1) << (2 * B));
    assign rem_w = {2'b00, rt_rem_r[k]};
    assign take  = rem_w >= trial;
    assign rt_rem_nxt[k+1]  = take ? D2_W'(rem_w - trial) : rt_rem_r[k];
    assign rt_root_nxt[k+1] = take ? (rt_root_r[k] | (ROOT_W'(1) << B)) : rt_root_r[k];
  end

  // Divider numerators: |d| * 2^30 plus half the distance for rounding.
  assign num[0] = ({32'd0, it_r[ST_E-1].ax} << UNIT_BITS) + {31'd0, rt_root_r[ROOT_W] >> 1};
  assign num[1] = ({32'd0, it_r[ST_E-1].ay} << UNIT_BITS) + {31'd0, rt_root_r[ROOT_W] >> 1};

  for (genvar a = 0; a < 2; a++) begin : g_axis
    assign dv_rem_nxt[a][0] = num[a][63:Q_W];
    assign dv_q_nxt[a][0]   = '0;
    for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int I = Q_W - 1 - k;
      logic [ROOT_W:0] t;
      logic            take;
      assign t    = {dv_rem_r[a][k], dv_low_r[a][k][I]};
      assign take = t >= {1'b0, dv_dist_r[k]};
      assign dv_rem_nxt[a][k+1] = take ? ROOT_W'(t - {1'b0, dv_dist_r[k]}) : t[ROOT_W-1:0];
      assign dv_q_nxt[a][k+1]   = take ? (dv_q_r[a][k] | (Q_W'(1) << I)) : dv_q_r[a][k];
    end
    assign cvrnd[a] = cv_r[a] + HALF_UNIT;
  end

  assign vmag = vs_r[63] ? 64'(-vs_r) : 64'(vs_r);
  assign vrnd = vmag + HALF_UNIT;

  always_comb begin
    logic signed [32:0] dx, dy;
    logic signed [35:0] off_x, off_y, cor_x, cor_y;
    dx = {in_pos_x[31], in_pos_x} - {cx_r[31], cx_r};
    dy = {in_pos_y[31], in_pos_y} - {cy_r[31], cy_r};
    it_nxt[0].act   = in_battle_active;
    it_nxt[0].clamp = 1'b0;
    it_nxt[0].start = 1'b0;
    it_nxt[0].neg_x = dx[32];
    it_nxt[0].neg_y = dy[32];
    it_nxt[0].ax    = dx[32] ? 32'(-dx) : dx[31:0];
    it_nxt[0].ay    = dy[32] ? 32'(-dy) : dy[31:0];
    it_nxt[0].pos_x = in_pos_x;
    it_nxt[0].pos_y = in_pos_y;
    it_nxt[0].pos_z = in_pos_z;
    it_nxt[0].vel_x = in_vel_x;
    it_nxt[0].vel_y = in_vel_y;
    it_nxt[0].vel_z = in_vel_z;
    for (int s = 1; s < NST; s++) begin
      it_nxt[s] = it_r[s-1];
    end
    // Inside tests compare the exact squared distance with the squared radius.
    it_nxt[ST_D].clamp = it_r[ST_D-1].act && en_r && (d2_r > {4'd0, ra2_r});
    it_nxt[ST_D].start = !it_r[ST_D-1].act && (d2_r <= {4'd0, re2_r});
    // Clamped position: centre plus the rounded unit vector times the radius.
    off_x = it_r[ST_M1+1].neg_x ? -$signed({4'd0, pr_r[0]}) : $signed({4'd0, pr_r[0]});
    off_y = it_r[ST_M1+1].neg_y ? -$signed({4'd0, pr_r[1]}) : $signed({4'd0, pr_r[1]});
    if (it_r[ST_M1+1].clamp) begin
      it_nxt[ST_M1+2].pos_x = sat32(36'(cx_r) + off_x);
      it_nxt[ST_M1+2].pos_y = sat32(36'(cy_r) + off_y);
    end
    // Outward speed removal, only when the speed along the unit vector is positive.
    cor_x = it_r[ST_M1+3].neg_x ? -$signed({2'd0, cvrnd[0][63:UNIT_BITS]})
                                : $signed({2'd0, cvrnd[0][63:UNIT_BITS]});
    cor_y = it_r[ST_M1+3].neg_y ? -$signed({2'd0, cvrnd[1][63:UNIT_BITS]})
                                : $signed({2'd0, cvrnd[1][63:UNIT_BITS]});
    if (it_r[ST_M1+3].clamp && s_pos4_r) begin
      it_nxt[ST_M1+4].vel_x = sat32(36'(it_r[ST_M1+3].vel_x) - cor_x);
      it_nxt[ST_M1+4].vel_y = sat32(36'(it_r[ST_M1+3].vel_y) - cor_y);
    end
  end

  // Configuration registers and the radius squares, which follow them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      ar_r <= '0;
      er_r <= '0;
      en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:      cx_r <= cfg_wdata;
        REG_CENTER_Y:      cy_r <= cfg_wdata;
        REG_ARENA_RADIUS:  ar_r <= cfg_wdata[30:0];
        REG_ENGAGE_RADIUS: er_r <= cfg_wdata[30:0];
        REG_CONFINE_EN:    en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
    ra2_r <= ar_r * ar_r;
    re2_r <= er_r * er_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [Q_W:0] ux, uy;
    if (adv) begin
      for (int s = 0; s < NST; s++) begin
        it_r[s] <= it_nxt[s];
      end
      sqx_r <= it_r[0].ax * it_r[0].ax;
      sqy_r <= it_r[0].ay * it_r[0].ay;
      d2_r  <= {2'b00, sqx_r} + {2'b00, sqy_r};
      for (int j = 0; j <= ROOT_W; j++) begin
        rt_rem_r[j]  <= rt_rem_nxt[j];
        rt_root_r[j] <= rt_root_nxt[j];
      end
      dv_dist_r[0] <= rt_root_r[ROOT_W];
      for (int j = 1; j <= Q_W; j++) begin
        dv_dist_r[j] <= dv_dist_r[j-1];
      end
      for (int a = 0; a < 2; a++) begin
        dv_low_r[a][0] <= num[a][Q_W-1:0];
        for (int j = 1; j <= Q_W; j++) begin
          dv_low_r[a][j] <= dv_low_r[a][j-1];
        end
        for (int j = 0; j <= Q_W; j++) begin
          dv_rem_r[a][j] <= dv_rem_nxt[a][j];
          dv_q_r[a][j]   <= dv_q_nxt[a][j];
        end
        q1_r[a] <= dv_q_r[a][Q_W];
        q2_r[a] <= q1_r[a];
        q3_r[a] <= q2_r[a];
        pm_r[a] <= dv_q_r[a][Q_W] * ar_r;
        pr_r[a] <= 32'((pm_r[a] + HALF_UNIT[61:0]) >> UNIT_BITS);
        cv_r[a] <= q3_r[a] * s_r;
      end
      ux = it_r[ST_M1-1].neg_x ? -{1'b0, dv_q_r[0][Q_W]} : {1'b0, dv_q_r[0][Q_W]};
      uy = it_r[ST_M1-1].neg_y ? -{1'b0, dv_q_r[1][Q_W]} : {1'b0, dv_q_r[1][Q_W]};
      vu_r[0]  <= it_r[ST_M1-1].vel_x * $signed(ux);
      vu_r[1]  <= it_r[ST_M1-1].vel_y * $signed(uy);
      vs_r     <= vu_r[0] + vu_r[1];
      s_r      <= vrnd[62:UNIT_BITS];
      s_pos_r  <= !vs_r[63] && (vrnd[62:UNIT_BITS] != '0);
      s_pos4_r <= s_pos_r;
    end
  end

  assign out_valid        = vld_r[NST-1];
  assign out_new_pos_x    = it_r[NST-1].pos_x;
  assign out_new_pos_y    = it_r[NST-1].pos_y;
  assign out_new_pos_z    = it_r[NST-1].pos_z;
  assign out_new_vel_x    = it_r[NST-1].vel_x;
  assign out_new_vel_y    = it_r[NST-1].vel_y;
  assign out_new_vel_z    = it_r[NST-1].vel_z;
  assign out_was_clamped  = it_r[NST-1].clamp;
  assign out_start_battle = it_r[NST-1].start;

  // A body is never both pushed back and reported as entering.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_clamped && out_start_battle))
    else $error("clamp and battle start both set");

  // An accepted transaction enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted transaction missing from first stage");

  // A clamped body is off centre, so the divisor is at least one.
  a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_E] && it_r[ST_E].clamp) |-> (dv_dist_r[0] != '0))
    else $error("zero distance on a clamped body");

  // A held output stage keeps its transaction while stalled.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_new_pos_x)))
    else $error("output changed during stall");

endmodule
